// ===== sv/assert_macros.svh =====
// Assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/eau_pkg.sv =====
package eau_pkg;

  localparam logic [3:0] MODE_ABS  = 4'd0;
  localparam logic [3:0] MODE_ABSX = 4'd1;
  localparam logic [3:0] MODE_ABSY = 4'd2;
  localparam logic [3:0] MODE_IMM  = 4'd3;
  localparam logic [3:0] MODE_IND  = 4'd4;
  localparam logic [3:0] MODE_XIND = 4'd5;
  localparam logic [3:0] MODE_INDY = 4'd6;
  localparam logic [3:0] MODE_REL  = 4'd7;
  localparam logic [3:0] MODE_ZPG  = 4'd8;
  localparam logic [3:0] MODE_ZPGX = 4'd9;
  localparam logic [3:0] MODE_ZPGY = 4'd10;
  localparam logic [3:0] MODE_LAST = MODE_ZPGY;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  localparam logic [15:0] ZP_MASK = 16'h00FF;

  typedef enum logic [1:0] {
    ST_REQ  = 2'd0,
    ST_DONE = 2'd1,
    ST_IGN  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_OPD_LO = 3'd1,
    PH_OPD_HI = 3'd2,
    PH_PTR_LO = 3'd3,
    PH_PTR_HI = 3'd4
  } phase_t;

  typedef struct packed {
    logic        op;
    logic [3:0]  mode;
    logic [15:0] prog_counter;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [7:0]  read_data;
  } eau_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] address;
    logic [15:0] next_pc;
  } eau_out_t;

  typedef struct packed {
    logic [3:0]  mode_held;
    logic [15:0] pc_held;
    logic [7:0]  x_held;
    logic [7:0]  y_held;
    phase_t      phase;
    logic [7:0]  low_byte;
    logic [15:0] pointer;
  } eau_state_t;

endpackage

// ===== sv/eau_step.sv =====
module eau_step import eau_pkg::*; (
  input  eau_state_t state,
  input  eau_in_t    item,
  output eau_state_t state_next,
  output eau_out_t   result
);

  logic [7:0]  b;
  logic [15:0] pc_plus1;
  logic [15:0] pc_plus2;
  logic [15:0] word;
  logic [15:0] rel_target;
  logic [15:0] ptr_plus1;
  logic [7:0]  zp_x;
  logic [7:0]  zp_y;

  assign b          = item.read_data;
  assign pc_plus1   = state.pc_held + 16'd1;
  assign pc_plus2   = state.pc_held + 16'd2;
  assign word       = {b, state.low_byte};
  assign rel_target = pc_plus1 + {{8{b[7]}}, b};
  assign ptr_plus1  = state.pointer + 16'd1;
  assign zp_x       = b + state.x_held;
  assign zp_y       = b + state.y_held;

  // next state
  always_comb begin
    state_next = state;
    if (item.op == OP_START) begin
      if (item.mode > MODE_LAST) begin
        state_next.phase = PH_IDLE;
      end else begin
        state_next.mode_held = item.mode;
        state_next.pc_held   = item.prog_counter;
        state_next.x_held    = item.index_x;
        state_next.y_held    = item.index_y;
        state_next.low_byte  = '0;
        state_next.pointer   = '0;
        state_next.phase     = PH_OPD_LO;
      end
    end else begin
      unique case (state.phase)
        PH_IDLE: ;
        PH_OPD_LO: begin
          case (state.mode_held) inside
            MODE_ABS, MODE_ABSX, MODE_ABSY, MODE_IND: begin
              state_next.low_byte = b;
              state_next.phase    = PH_OPD_HI;
            end
            MODE_XIND: begin
              state_next.pointer = {8'h00, zp_x};
              state_next.phase   = PH_PTR_LO;
            end
            MODE_INDY: begin
              state_next.pointer = {8'h00, b};
              state_next.phase   = PH_PTR_LO;
            end
            default: state_next.phase = PH_IDLE;
          endcase
        end
        PH_OPD_HI: begin
          if (state.mode_held == MODE_IND) begin
            state_next.pointer = word;
            state_next.phase   = PH_PTR_LO;
          end else begin
            state_next.phase = PH_IDLE;
          end
        end
        PH_PTR_LO: begin
          state_next.low_byte = b;
          state_next.phase    = PH_PTR_HI;
        end
        PH_PTR_HI: state_next.phase = PH_IDLE;
        default:   state_next.phase = PH_IDLE;
      endcase
    end
  end

  // result beat
  always_comb begin
    result = '{status: ST_IGN, address: 16'h0000, next_pc: 16'h0000};
    if (item.op == OP_START) begin
      if (item.mode <= MODE_LAST) begin
        result.status  = ST_REQ;
        result.address = item.prog_counter;
      end
    end else begin
      unique case (state.phase)
        PH_IDLE: ;
        PH_OPD_LO: begin
          case (state.mode_held) inside
            MODE_ABS, MODE_ABSX, MODE_ABSY, MODE_IND: begin
              result.status  = ST_REQ;
              result.address = pc_plus1;
            end
            MODE_IMM, MODE_ZPG: begin
              result = '{status: ST_DONE, address: {8'h00, b}, next_pc: pc_plus1};
            end
            MODE_XIND: begin
              result.status  = ST_REQ;
              result.address = {8'h00, zp_x};
            end
            MODE_INDY: begin
              result.status  = ST_REQ;
              result.address = {8'h00, b};
            end
            MODE_REL: begin
              result = '{status: ST_DONE, address: rel_target, next_pc: pc_plus1};
            end
            MODE_ZPGX: begin
              result = '{status: ST_DONE, address: {8'h00, zp_x} & ZP_MASK,
                         next_pc: pc_plus1};
            end
            MODE_ZPGY: begin
              result = '{status: ST_DONE, address: {8'h00, zp_y} & ZP_MASK,
                         next_pc: pc_plus1};
            end
            default: ;
          endcase
        end
        PH_OPD_HI: begin
          case (state.mode_held)
            MODE_ABS:  result = '{status: ST_DONE, address: word, next_pc: pc_plus2};
            MODE_ABSX: result = '{status: ST_DONE, address: word + {8'h00, state.x_held},
                                  next_pc: pc_plus2};
            MODE_ABSY: result = '{status: ST_DONE, address: word + {8'h00, state.y_held},
                                  next_pc: pc_plus2};
            MODE_IND: begin
              result.status  = ST_REQ;
              result.address = word;
            end
            default: ;
          endcase
        end
        PH_PTR_LO: begin
          result.status  = ST_REQ;
          result.address = ptr_plus1;
        end
        PH_PTR_HI: begin
          case (state.mode_held)
            MODE_IND:  result = '{status: ST_DONE, address: word, next_pc: pc_plus2};
            MODE_XIND: result = '{status: ST_DONE, address: word, next_pc: pc_plus1};
            MODE_INDY: result = '{status: ST_DONE, address: word + {8'h00, state.y_held},
                                  next_pc: pc_plus1};
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/cpu_effective_address_unit_core.sv =====
// Effective address unit for the eleven 6502-style addressing modes.
// Input channel (in_valid / in_stall / in_data): each beat is either a
// start (op = 0: mode, prog_counter, index_x, index_y) or a returned
// memory byte (op = 1: read_data).
// Output channel (out_valid / out_stall / out_data): exactly one beat per
// input beat: a read request (status 0, address to fetch), the finished
// effective address with the advanced PC (status 1), or an ignored item
// (status 2, address and next_pc zero).
// Each accepted beat is registered in the input register, then passes
// through the step logic into the result register when the output is free.
// Throughput: one beat per cycle while the receiver does not stall; the
// input register and the result register form a two-deep pipeline, and
// each beat needs only one pass of adders and muxes in the step logic.
// When the receiver stalls, the result beat holds; one more beat waits in
// the input register, then in_stall rises.
// Reset (rst, synchronous): both stages empty, sequencer idle with all
// held values zero.
module cpu_effective_address_unit_core import eau_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  eau_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output eau_out_t out_data
);

  // input register
  logic       s1_valid;
  eau_in_t    s1_item;

  // sequencer state
  eau_state_t state;
  eau_state_t state_next;
  eau_out_t   step_result;

  logic       advance;

  // the staged beat moves on when the result register is empty or drains
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  eau_step u_step (
    .state      (state),
    .item       (s1_item),
    .state_next (state_next),
    .result     (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item <= in_data;
    end
  end

  // state commits only when the beat leaves for the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{mode_held: '0, pc_held: '0, x_held: '0, y_held: '0,
                 phase: PH_IDLE, low_byte: '0, pointer: '0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= step_result;
    end
  end

endmodule

// ===== sv/eau_checker.sv =====
`include "assert_macros.svh"

module eau_checker import eau_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     out_valid,
  input logic     out_stall,
  input eau_out_t out_data
);

  `ASSERT_CLK_RST(a_reset_empty, rst |=> !out_valid, "output valid after reset")
  `ASSERT_CLK(a_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled beat changed")
  `ASSERT_CLK(a_status_code, out_valid |-> out_data.status != 2'd3, "bad status code")
  `ASSERT_CLK(a_quiet_fields, out_valid && out_data.status != ST_DONE |-> out_data.next_pc == 16'h0000 && (out_data.status != ST_IGN || out_data.address == 16'h0000), "nonzero unused field")

endmodule

bind cpu_effective_address_unit_core eau_checker u_eau_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
